// ----- rtl/core/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants for the prime sieve table unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

	localparam int TABLE_DEPTH = 32768;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	// counts up to and including TABLE_DEPTH
	localparam int CNT_W       = ADDR_W + 1;
	localparam int LIMIT_W     = 16;
	localparam int NUMBER_W    = 15;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd26212;

	localparam logic OP_BUILD   = 1'b0;
	localparam logic OP_QUERY   = 1'b1;
	localparam logic KIND_BUILT = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_BCHK,
		ST_BWAIT,
		ST_MARK,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/core/pst_ram.sv -----
// ----------------------------------------------------------------------------
// pst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pst_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/prime_sieve_table_unit.sv -----
// ----------------------------------------------------------------------------
// prime_sieve_table_unit
// One-bit primality table, rebuilt by a sequenced Sieve of Eratosthenes.
// ----------------------------------------------------------------------------
// Query: result strobe in the cycle after the transfer; queries may follow every
//   cycle (busy stays low).
// Rebuild: fill entries below max(L,2); each prime base with base^2 < L clears
//   base^2 to L-1 in steps of base; L = min(limit, table depth); one write port.
// Results cannot be stalled. Reset: limit 26212, table reads as all zero
//   (entries never written are masked by a written-range mark, no clear pass).
`timescale 1ns / 1ps
`default_nettype none

module prime_sieve_table_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire logic                          operation,
	input  wire logic [pst_pkg::NUMBER_W-1:0]  number,
	output      logic                          result_valid,
	output      logic                          answer_kind,
	output      logic                          prime_flag,
	output      logic                          out_of_range,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [pst_pkg::LIMIT_W-1:0]   cfg_data
);

	import pst_pkg::*;

	state_t              state_q, state_d;
	logic [LIMIT_W-1:0]  limit_q;
	logic [CNT_W-1:0]    eff_lim;
	logic [CNT_W-1:0]    fill_end;
	logic [CNT_W-1:0]    lim_q;
	logic [CNT_W-1:0]    fill_end_q;
	logic [CNT_W-1:0]    hwm_q;
	logic [CNT_W:0]      k_q;
	logic [CNT_W-1:0]    base_q;
	logic [CNT_W:0]      sq_q;
	logic [CNT_W:0]      k_next;
	logic [CNT_W:0]      sq_next;
	logic                q_pend_q, q_ok_q, q_oor_q;
	logic                accept, acc_build, acc_query;
	logic                fill_last, mark_last, sieve_end;

	logic                ram_we, ram_wdata, ram_re, ram_rdata;
	logic [ADDR_W-1:0]   ram_waddr, ram_raddr;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign acc_build = accept && (operation == OP_BUILD);
	assign acc_query = accept && (operation == OP_QUERY);

	assign eff_lim  = (32'(limit_q) >= 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
	                                                      : CNT_W'(limit_q);
	// entries 0 and 1 are always written, even for a tiny limit
	assign fill_end = (eff_lim < CNT_W'(2)) ? CNT_W'(2) : eff_lim;

	assign k_next    = (state_q == ST_MARK) ? (k_q + (CNT_W+1)'(base_q))
	                                        : (k_q + (CNT_W+1)'(1));
	assign sq_next   = sq_q + {base_q, 1'b1};
	assign fill_last = (k_next == {1'b0, fill_end_q});
	assign mark_last = (k_next >= {1'b0, lim_q});
	assign sieve_end = (sq_q >= {1'b0, lim_q});

	pst_ram #(
		.WIDTH (1),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr   (ram_raddr),
		.rdata_q (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (acc_build) state_d = ST_FILL;
			ST_FILL:  if (fill_last) state_d = ST_BCHK;
			ST_BCHK:  state_d = sieve_end ? ST_DONE : ST_BWAIT;
			ST_BWAIT: state_d = ram_rdata ? ST_MARK : ST_BCHK;
			ST_MARK:  if (mark_last) state_d = ST_BCHK;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q[ADDR_W-1:0];
		ram_wdata = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = ADDR_W'(number);
		case (state_q)
			ST_IDLE: begin
				ram_re = acc_query;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = (k_q >= (CNT_W+1)'(2));
			end
			ST_BCHK: begin
				ram_re    = !sieve_end;
				ram_raddr = base_q[ADDR_W-1:0];
			end
			ST_MARK: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			limit_q  <= LIMIT_RESET;
			hwm_q    <= '0;
			q_pend_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			q_pend_q <= acc_query;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (acc_build && (fill_end > hwm_q)) begin
				hwm_q <= fill_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_query) begin
			q_oor_q <= (32'(number) >= 32'(eff_lim));
			q_ok_q  <= (32'(number) < 32'(eff_lim)) && (32'(number) < 32'(hwm_q));
		end
		case (state_q)
			ST_IDLE: begin
				lim_q      <= eff_lim;
				fill_end_q <= fill_end;
				k_q        <= '0;
				base_q     <= CNT_W'(2);
				sq_q       <= (CNT_W+1)'(4);
			end
			ST_FILL: begin
				k_q <= k_next;
			end
			ST_BWAIT: begin
				if (ram_rdata) begin
					k_q <= sq_q;
				end else begin
					base_q <= base_q + CNT_W'(1);
					sq_q   <= sq_next;
				end
			end
			ST_MARK: begin
				k_q <= k_next;
				if (mark_last) begin
					base_q <= base_q + CNT_W'(1);
					sq_q   <= sq_next;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = q_pend_q || (state_q == ST_DONE);
	assign answer_kind  = q_pend_q ? KIND_QUERY : KIND_BUILT;
	assign prime_flag   = q_pend_q && q_ok_q && ram_rdata;
	assign out_of_range = q_pend_q && q_oor_q;

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pend_q && (state_q == ST_DONE)))
		else $error("query answer and rebuild done in the same cycle");

	a_query_answer: assert property (@(posedge clk) disable iff (!arst_n)
		acc_query |=> (result_valid && (answer_kind == KIND_QUERY)))
		else $error("query transfer without answer next cycle");

	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> (k_q < {1'b0, lim_q}))
		else $error("multiple cleared at or above the limit");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_of_range |-> !prime_flag)
		else $error("out of range answer marked prime");

endmodule

`default_nettype wire
